/* rtl/core/itoa_pkg.sv */
// Shared types and constants for the signed integer to decimal ASCII unit.
// No dependencies; used by itoa_back and signed_int_to_decimal_ascii_unit.
package itoa_pkg;

  localparam int CHAR_BITS   = 7;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 7'd48;
  localparam logic [CHAR_BITS-1:0] ASCII_NINE  = 7'd57;
  localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 7'd45;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CONV,
    B_SKIP,
    B_SIGN,
    B_EMIT
  } back_state_t;

  typedef struct packed {
    logic [CHAR_BITS-1:0] ch;
    logic                 last;
  } char_beat_t;

endpackage

/* rtl/core/itoa_front.sv */
// Front end: accepts a request and splits it into sign and magnitude.
// Depends on nothing beyond its parameter.
module itoa_front #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  s_valid,
  output logic                  s_ready,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  push_valid,
  input  logic                  push_ready,
  output logic                  push_neg,
  output logic [VALUE_BITS-1:0] push_mag
);

  logic neg;

  // The magnitude fits VALUE_BITS unsigned bits, the most negative value included.
  assign neg        = value[VALUE_BITS-1];
  assign push_neg   = neg;
  assign push_mag   = neg ? (~value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : value;
  assign push_valid = s_valid;
  assign s_ready    = push_ready;

endmodule

/* rtl/core/itoa_fifo.sv */
// Short queue between the front end and the back end.
// Depends on nothing beyond its parameters.
module itoa_fifo #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

/* rtl/core/itoa_back.sv */
// Back end: shift-and-add-3 binary to BCD conversion, then character output.
// Depends on itoa_pkg (state enum, ASCII constants, output beat struct).
module itoa_back #(
  parameter int VALUE_BITS = 32,
  parameter int NDIG       = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  logic                  q_neg,
  input  logic [VALUE_BITS-1:0] q_mag,
  output logic                  out_valid,
  input  logic                  out_ready,
  output itoa_pkg::char_beat_t  out_beat
);

  localparam int BW = NDIG * 4;
  localparam int CW = $clog2(VALUE_BITS + 1);
  localparam int DW = $clog2(NDIG + 1);

  itoa_pkg::back_state_t state;
  itoa_pkg::back_state_t state_next;

  logic [VALUE_BITS-1:0] sh;
  logic [BW-1:0]         bcd;
  logic [BW-1:0]         bcd_adj;
  logic                  neg;
  logic [CW-1:0]         bit_cnt;
  logic [DW-1:0]         dig_left;
  logic [3:0]            top_digit;
  logic                  slot_free;
  logic                  load_out;
  logic                  emit_minus;
  logic                  skip_zero;

  assign top_digit = bcd[BW-1 -: 4];
  assign slot_free = !out_valid || out_ready;
  assign skip_zero = (top_digit == 4'd0) && (dig_left != DW'(1));

  // Add 3 to every digit of 5 or more before the shift.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itoa_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    load_out   = 1'b0;
    emit_minus = 1'b0;
    unique case (state)
      itoa_pkg::B_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          state_next = itoa_pkg::B_CONV;
        end
      end
      itoa_pkg::B_CONV: begin
        if (bit_cnt == CW'(1)) begin
          state_next = itoa_pkg::B_SKIP;
        end
      end
      itoa_pkg::B_SKIP: begin
        if (!skip_zero) begin
          state_next = neg ? itoa_pkg::B_SIGN : itoa_pkg::B_EMIT;
        end
      end
      itoa_pkg::B_SIGN: begin
        if (slot_free) begin
          load_out   = 1'b1;
          emit_minus = 1'b1;
          state_next = itoa_pkg::B_EMIT;
        end
      end
      itoa_pkg::B_EMIT: begin
        if (slot_free) begin
          load_out = 1'b1;
          if (dig_left == DW'(1)) begin
            state_next = itoa_pkg::B_IDLE;
          end
        end
      end
      default: state_next = itoa_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == itoa_pkg::B_IDLE && q_valid) begin
      sh       <= q_mag;
      bcd      <= '0;
      neg      <= q_neg;
      bit_cnt  <= CW'(VALUE_BITS);
      dig_left <= DW'(NDIG);
    end else if (state == itoa_pkg::B_CONV) begin
      bcd     <= {bcd_adj[BW-2:0], sh[VALUE_BITS-1]};
      sh      <= {sh[VALUE_BITS-2:0], 1'b0};
      bit_cnt <= bit_cnt - CW'(1);
    end else if ((state == itoa_pkg::B_SKIP && skip_zero) ||
                 (state == itoa_pkg::B_EMIT && slot_free)) begin
      bcd      <= {bcd[BW-5:0], 4'd0};
      dig_left <= dig_left - DW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_beat.ch   <= emit_minus ? itoa_pkg::ASCII_MINUS
                                  : itoa_pkg::ASCII_ZERO + itoa_pkg::CHAR_BITS'(top_digit);
      out_beat.last <= !emit_minus && (dig_left == DW'(1));
    end
  end

`ifndef SYNTHESIS
  a_emit_has_digit: assert property (@(posedge clk) disable iff (rst)
    state == itoa_pkg::B_EMIT |-> dig_left != '0)
    else $error("emit state with no digit left");

  a_bcd_digit_range: assert property (@(posedge clk) disable iff (rst)
    (state == itoa_pkg::B_SKIP || state == itoa_pkg::B_EMIT) |-> top_digit <= 4'd9)
    else $error("BCD digit out of range");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_beat.ch == itoa_pkg::ASCII_MINUS ||
                   (out_beat.ch >= itoa_pkg::ASCII_ZERO && out_beat.ch <= itoa_pkg::ASCII_NINE)))
    else $error("output character is neither sign nor digit");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_beat.ch == itoa_pkg::ASCII_MINUS) |-> !out_beat.last)
    else $error("minus sign flagged as last character");
`endif

endmodule

/* rtl/core/signed_int_to_decimal_ascii_unit.sv */
// Signed integer to decimal ASCII: one request in, its decimal characters out.
// The back end takes one request at a time: a BCD shift, a scan past leading zeros,
// then a minus sign for a negative value and the digits; the queue holds further requests.
// Reset: synchronous, active high; empties the queue and drops any pending output.
// Depends on itoa_pkg, itoa_front, itoa_fifo and itoa_back.
module signed_int_to_decimal_ascii_unit #(
  parameter int VALUE_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_tdata,  // [VALUE_BITS-1:0] value, zero pad
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [7:0]                           m_tdata,  // [6:0] char_out, [7] zero pad
  output logic                                 m_tlast
);

  // Decimal digits needed for the largest magnitude: 0.31 per bit rounds up safely.
  localparam int NDIG = (VALUE_BITS * 31) / 100 + 1;
  localparam int QW   = VALUE_BITS + 1;

  logic                  push_valid;
  logic                  push_ready;
  logic                  push_neg;
  logic [VALUE_BITS-1:0] push_mag;
  logic                  pop_valid;
  logic                  pop_ready;
  logic [QW-1:0]         pop_data;
  itoa_pkg::char_beat_t  beat;

  // Front: classify sign and form the unsigned magnitude as the request arrives.
  itoa_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .s_valid    (s_tvalid),
    .s_ready    (s_tready),
    .value      (s_tdata[VALUE_BITS-1:0]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_neg   (push_neg),
    .push_mag   (push_mag)
  );

  // Queue: hold up to QUEUE_DEPTH classified requests so the input need not wait
  // on a stalled serial output while the back end is busy, until the queue is full.
  itoa_fifo #(
    .WIDTH (QW),
    .DEPTH (itoa_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_neg, push_mag}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back: convert to BCD one bit a cycle, drop leading zeros one digit a
  // cycle, then send sign and digits through its output register.
  itoa_back #(
    .VALUE_BITS (VALUE_BITS),
    .NDIG       (NDIG)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (pop_valid),
    .q_ready   (pop_ready),
    .q_neg     (pop_data[QW-1]),
    .q_mag     (pop_data[VALUE_BITS-1:0]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_beat  (beat)
  );

  assign m_tdata = {1'b0, beat.ch};
  assign m_tlast = beat.last;

endmodule
